// ----- rtl/abu_pkg.sv -----
// shared types, constants and helpers of the aligned bitmap unit allocator
`default_nettype none
package abu_pkg;

  localparam int NUM_UNITS = 4096;
  localparam int UNIT_W    = 12;
  localparam int CNT_W     = 13;
  localparam int WORD_W    = 64;
  localparam int WORDS     = 64;
  localparam int WADDR_W   = 6;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ZERO_SIZE = 3'd1;
  localparam logic [2:0] ST_NO_SPACE  = 3'd2;
  localparam logic [2:0] ST_RANGE     = 3'd3;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd4;

  typedef enum logic [1:0] {
    K_ALLOC,
    K_FREE,
    K_IMM
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [2:0]        imm_status;
    logic [CNT_W-1:0]  nr;
    logic [UNIT_W-1:0] al_mask;
    logic [UNIT_W-1:0] fbit;
  } cmd_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [15:0]      alloc_offset;
    logic [CNT_W-1:0] freed_units;
  } res_t;

  // alignment mask: pow2_up(v + 1) - 1, low bits only
  function automatic logic [UNIT_W-1:0] pow2_mask(input logic [12:0] v);
    logic [12:0] m;
    m = v;
    m = m | (m >> 1);
    m = m | (m >> 2);
    m = m | (m >> 4);
    m = m | (m >> 8);
    return m[UNIT_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/abu_ram.sv -----
// generic single write, single read memory with registered read data
`default_nettype none
module abu_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = $clog2(D)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/abu_front.sv -----
// front end: accepts requests, converts them to units and queues commands
`default_nettype none
module abu_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_push,
  output logic               in_full,
  input  wire logic          in_op,
  input  wire logic [15:0]   in_size_bytes,
  input  wire logic [16:0]   in_align_bytes,
  input  wire logic [19:0]   in_free_offset,
  input  wire logic [13:0]   start_units,
  input  wire logic          hold,
  input  wire logic          cmd_pop,
  output logic               cmd_valid,
  output abu_pkg::cmd_t      cmd
);
  abu_pkg::cmd_t cls;
  abu_pkg::cmd_t q_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          acc;
  logic [16:0]   nr_sum;
  logic [17:0]   al_sum;
  logic [13:0]   al;
  logic [17:0]   sbytes;
  logic          oor;

  always_comb begin
    nr_sum = {1'b0, in_size_bytes} + 17'd15;
    al_sum = {1'b0, in_align_bytes} + 18'd15;
    al     = (al_sum[17:4] == 14'd0) ? 14'd1 : al_sum[17:4];
    sbytes = {start_units, 4'b0};
    oor    = ({2'b0, in_free_offset} < {4'b0, sbytes}) || (in_free_offset[19:16] != 4'd0);
    cls            = '0;
    cls.nr         = nr_sum[16:4];
    cls.al_mask    = abu_pkg::pow2_mask(13'(al - 14'd1));
    cls.fbit       = in_free_offset[15:4] - start_units[11:0];
    cls.imm_status = abu_pkg::ST_OK;
    if (!in_op) begin
      if (in_size_bytes == 16'd0) begin
        cls.kind       = abu_pkg::K_IMM;
        cls.imm_status = abu_pkg::ST_ZERO_SIZE;
      end else begin
        cls.kind = abu_pkg::K_ALLOC;
      end
    end else if (oor) begin
      cls.kind       = abu_pkg::K_IMM;
      cls.imm_status = abu_pkg::ST_RANGE;
    end else begin
      cls.kind = abu_pkg::K_FREE;
    end
  end

  assign in_full   = hold || (cnt_r == 2'd2);
  assign acc       = in_push && !in_full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (acc) begin
        wp_r <= !wp_r;
      end
      if (cmd_pop && cmd_valid) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, acc} - {1'b0, cmd_pop && cmd_valid};
    end
    if (acc) begin
      q_r[wp_r] <= cls;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/abu_back.sv -----
// back end: bitmap search, run marking and release over word memories
`default_nettype none
module abu_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cmd_valid,
  input  abu_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  input  wire logic [12:0]   nbits,
  input  wire logic [11:0]   start_units,
  input  wire logic          res_full,
  output logic               res_push,
  output abu_pkg::res_t      res,
  output logic               clearing
);
  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_SRD, S_SCAN, S_MRD, S_MWR, S_FRD, S_FCHK, S_DONE
  } state_t;

  state_t        state_r, state_nxt;
  logic [5:0]    clr_r, clr_nxt;
  abu_pkg::cmd_t cmd_r, cmd_nxt;
  logic [5:0]    w_r, w_nxt;
  logic [2:0]    slice_r, slice_nxt;
  logic [11:0]   cand_r, cand_nxt;
  logic [12:0]   cnt_r, cnt_nxt;
  logic [11:0]   lo_r, lo_nxt;
  logic [12:0]   hi_r, hi_nxt;
  logic [5:0]    rw_r, rw_nxt;
  logic [5:0]    rend_r, rend_nxt;
  logic          set_r, set_nxt;
  abu_pkg::res_t res_r, res_nxt;

  logic [5:0]    maddr;
  logic          bm_we, sm_we, rl_we;
  logic [63:0]   bm_wd, sm_wd, bm_rd, sm_rd, mask, onebit;
  logic [12:0]   rl_rd;

  // scan and free check temporaries
  logic [12:0]   c;
  logic [11:0]   b;
  logic          fnd;
  logic [11:0]   pos;
  logic          fr;
  logic [12:0]   hsum, hend, len;
  logic [13:0]   fsum;
  logic [11:0]   mpos;

  abu_ram #(.W(64), .D(64)) u_bm (
    .clk(clk), .we(bm_we), .waddr(maddr), .wdata(bm_wd), .raddr(maddr), .rdata(bm_rd)
  );
  abu_ram #(.W(64), .D(64)) u_sm (
    .clk(clk), .we(sm_we), .waddr(maddr), .wdata(sm_wd), .raddr(maddr), .rdata(sm_rd)
  );
  abu_ram #(.W(13), .D(4096)) u_rl (
    .clk(clk), .we(rl_we), .waddr(lo_r), .wdata(cmd_r.nr), .raddr(cmd_r.fbit),
    .rdata(rl_rd)
  );

  // eight units per cycle in the scan state, first aligned free run of nr units
  always_comb begin
    c   = cnt_r;
    b   = cand_r;
    fnd = 1'b0;
    pos = '0;
    fr  = 1'b0;
    for (int k = 0; k < 8; k++) begin
      pos = {w_r, slice_r, 3'(k)};
      fr  = !bm_rd[{slice_r, 3'(k)}] && ({1'b0, pos} < nbits);
      if (!fnd) begin
        if (!fr) begin
          c = 13'd0;
        end else if (c == 13'd0) begin
          if ((pos & cmd_r.al_mask) == 12'd0) begin
            b = pos;
            c = 13'd1;
          end
        end else begin
          c = c + 13'd1;
        end
        if (c == cmd_r.nr) begin
          fnd = 1'b1;
        end
      end
    end
  end

  always_comb begin
    mpos = '0;
    for (int k = 0; k < 64; k++) begin
      mpos    = {rw_r, 6'(k)};
      mask[k] = (mpos >= lo_r) && ({1'b0, mpos} < hi_r);
    end
    onebit = 64'd1 << lo_r[5:0];
  end

  always_comb begin
    hsum = {1'b0, b} + cmd_r.nr;
    hend = hsum - 13'd1;
    len  = sm_rd[cmd_r.fbit[5:0]] ? rl_rd : 13'd0;
    fsum = {2'b0, cmd_r.fbit} + {1'b0, len};
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cmd_nxt   = cmd_r;
    w_nxt     = w_r;
    slice_nxt = slice_r;
    cand_nxt  = cand_r;
    cnt_nxt   = cnt_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    rw_nxt    = rw_r;
    rend_nxt  = rend_r;
    set_nxt   = set_r;
    res_nxt   = res_r;
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    maddr     = w_r;
    bm_we     = 1'b0;
    sm_we     = 1'b0;
    rl_we     = 1'b0;
    bm_wd     = '0;
    sm_wd     = '0;
    case (state_r)
      S_CLR: begin
        maddr = clr_r;
        bm_we = 1'b1;
        sm_we = 1'b1;
        clr_nxt = clr_r + 6'd1;
        if (clr_r == 6'd63) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop   = 1'b1;
          cmd_nxt   = cmd;
          w_nxt     = '0;
          slice_nxt = '0;
          cnt_nxt   = '0;
          res_nxt   = '0;
          case (cmd.kind)
            abu_pkg::K_ALLOC: state_nxt = S_SRD;
            abu_pkg::K_FREE:  state_nxt = S_FRD;
            default: begin
              res_nxt.status = cmd.imm_status;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end
      S_SRD: begin
        maddr     = w_r;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        maddr = w_r;
        if (fnd) begin
          lo_nxt  = b;
          hi_nxt  = hsum;
          rw_nxt  = b[11:6];
          rend_nxt = hend[11:6];
          set_nxt = 1'b1;
          res_nxt.status       = abu_pkg::ST_OK;
          res_nxt.alloc_offset = {12'(start_units + b), 4'b0};
          state_nxt = S_MRD;
        end else begin
          cand_nxt  = b;
          cnt_nxt   = c;
          slice_nxt = slice_r + 3'd1;
          if (slice_r == 3'd7) begin
            w_nxt = w_r + 6'd1;
            if (w_r == 6'd63) begin
              res_nxt.status = abu_pkg::ST_NO_SPACE;
              state_nxt      = S_DONE;
            end else begin
              state_nxt = S_SRD;
            end
          end
        end
      end
      S_FRD: begin
        maddr     = cmd_r.fbit[11:6];
        state_nxt = S_FCHK;
      end
      S_FCHK: begin
        maddr = cmd_r.fbit[11:6];
        if (!bm_rd[cmd_r.fbit[5:0]]) begin
          res_nxt.status = abu_pkg::ST_NOT_ALLOC;
          state_nxt      = S_DONE;
        end else if (len == 13'd0) begin
          res_nxt.status = abu_pkg::ST_OK;
          state_nxt      = S_DONE;
        end else begin
          // runs are clipped at the last unit of the chunk
          lo_nxt   = cmd_r.fbit;
          hi_nxt   = (fsum > 14'd4096) ? 13'd4096 : fsum[12:0];
          rw_nxt   = cmd_r.fbit[11:6];
          rend_nxt = (fsum > 14'd4096) ? 6'd63 : 6'((fsum - 14'd1) >> 6);
          set_nxt  = 1'b0;
          res_nxt.status      = abu_pkg::ST_OK;
          res_nxt.freed_units = len;
          state_nxt = S_MWR;
        end
      end
      S_MRD: begin
        maddr     = rw_r;
        state_nxt = S_MWR;
      end
      S_MWR: begin
        maddr = rw_r;
        bm_we = 1'b1;
        bm_wd = set_r ? (bm_rd | mask) : (bm_rd & ~mask);
        sm_we = (rw_r == lo_r[11:6]);
        sm_wd = set_r ? (sm_rd | onebit) : (sm_rd & ~onebit);
        rl_we = set_r && (rw_r == lo_r[11:6]);
        rw_nxt = rw_r + 6'd1;
        state_nxt = (rw_r == rend_r) ? S_DONE : S_MRD;
      end
      S_DONE: begin
        if (!res_full) begin
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign res      = res_r;
  assign clearing = (state_r == S_CLR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
    cmd_r   <= cmd_nxt;
    w_r     <= w_nxt;
    slice_r <= slice_nxt;
    cand_r  <= cand_nxt;
    cnt_r   <= cnt_nxt;
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    rw_r    <= rw_nxt;
    rend_r  <= rend_nxt;
    set_r   <= set_nxt;
    res_r   <= res_nxt;
  end
endmodule
`default_nettype wire

// ----- rtl/abu_res_q.sv -----
// two-entry result queue in front of the output ports
`default_nettype none
module abu_res_q (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  abu_pkg::res_t   din,
  output logic            full,
  input  wire logic       pop,
  output logic            empty,
  output abu_pkg::res_t   dout
);
  abu_pkg::res_t q_r [2];
  logic          wp_r, rp_r;
  logic [1:0]    cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wp_r <= !wp_r;
      end
      if (do_pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
    if (do_push) begin
      q_r[wp_r] <= din;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/aligned_bitmap_unit_allocator.sv -----
// top level of the aligned bitmap unit allocator
// the block hands out runs of 16-byte units from a 64 KiB chunk, above a
// configured static area (dynamic_start_bytes at byte address 0, rounded up to
// a unit). requests enter a two-entry command queue through push/full; the
// front converts sizes and alignments to units and resolves zero-size and
// out-of-range requests at once. the back works one command at a time on a
// 64 x 64-bit in-use bitmap, a 64 x 64-bit run-start bitmap and a 4096-entry
// run-length memory. an allocate reads each 64-unit word of the bitmap and
// scans it eight units a cycle, then marks the run with a read and a write per
// word touched. a free reads and checks the start unit, then clears the
// released run with a read and a write per word. immediate results go straight
// to the result stage. after reset a clearing pass wipes both bitmaps; full
// stays high during it, configuration writes are taken as usual. results wait
// in a two-entry queue read through empty/pop
`default_nettype none
module aligned_bitmap_unit_allocator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // request beats
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic        in_op,
  input  wire logic [15:0] in_size_bytes,
  input  wire logic [16:0] in_align_bytes,
  input  wire logic [19:0] in_free_offset,
  // result beats
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [2:0]       out_status,
  output logic [15:0]      out_alloc_offset,
  output logic [12:0]      out_freed_units,
  // configuration
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  logic [16:0]   start_r;
  logic [17:0]   start_sum;
  logic [13:0]   start_units;
  logic [12:0]   nbits;
  logic          hold;
  logic          cmd_valid, cmd_pop;
  abu_pkg::cmd_t cmd;
  logic          res_push, res_full;
  abu_pkg::res_t res, res_head;

  // start register, one word at byte address 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && !cfg_paddr[2]) begin
      start_r <= cfg_pwdata[16:0];
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {15'd0, start_r};

  // area start in units and area size; an area past the chunk is empty
  assign start_sum   = {1'b0, start_r} + 18'd15;
  assign start_units = start_sum[17:4];
  assign nbits       = (start_units >= 14'd4096) ? 13'd0 : 13'(14'd4096 - start_units);

  abu_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_op(in_op),
    .in_size_bytes(in_size_bytes), .in_align_bytes(in_align_bytes),
    .in_free_offset(in_free_offset), .start_units(start_units), .hold(hold),
    .cmd_pop(cmd_pop), .cmd_valid(cmd_valid), .cmd(cmd)
  );

  abu_back u_back (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .nbits(nbits), .start_units(start_units[11:0]),
    .res_full(res_full), .res_push(res_push), .res(res), .clearing(hold)
  );

  abu_res_q u_res_q (
    .clk(clk), .rst_n(rst_n),
    .push(res_push), .din(res), .full(res_full),
    .pop(out_pop), .empty(out_empty), .dout(res_head)
  );

  assign out_status       = res_head.status;
  assign out_alloc_offset = res_head.alloc_offset;
  assign out_freed_units  = res_head.freed_units;
endmodule
`default_nettype wire

// ----- rtl/abu_chk.sv -----
// port-level checker of the aligned bitmap unit allocator and its bind
`default_nettype none
module abu_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_push,
  input wire logic        in_full,
  input wire logic        in_op,
  input wire logic [15:0] in_size_bytes,
  input wire logic [16:0] in_align_bytes,
  input wire logic [19:0] in_free_offset,
  input wire logic        out_empty,
  input wire logic        out_pop,
  input wire logic [2:0]  out_status,
  input wire logic [15:0] out_alloc_offset,
  input wire logic [12:0] out_freed_units,
  input wire logic        cfg_psel,
  input wire logic        cfg_penable,
  input wire logic        cfg_pwrite,
  input wire logic [2:0]  cfg_paddr,
  input wire logic [31:0] cfg_pwdata,
  input wire logic [31:0] cfg_prdata,
  input wire logic        cfg_pready
);
  // results queue comes out of reset empty
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // the clearing pass holds off requests right after reset
  a_reset_full: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("requests taken during clearing pass");

  // a waiting result holds until popped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_status)
      && $stable(out_alloc_offset) && $stable(out_freed_units)))
    else $error("waiting result changed");

  // failed operations report no offset and no freed units
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != abu_pkg::ST_OK) |->
      (out_alloc_offset == 16'd0 && out_freed_units == 13'd0))
    else $error("failed result carries payload");

  // the start register moves only on a write
  a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(cfg_psel && cfg_penable && cfg_pwrite) |=> $stable(cfg_prdata))
    else $error("register changed without a write");
endmodule

bind aligned_bitmap_unit_allocator abu_chk u_abu_chk (.*);
`default_nettype wire

// ----- tb/aligned_bitmap_unit_allocator_tb.sv -----
// self-checking testbench of the aligned bitmap unit allocator
`default_nettype none
module aligned_bitmap_unit_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // config register map: dynamic start at byte address 0
  localparam logic [2:0] REG_DYN_START = 3'd0;
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;
  localparam int   LIMIT_CYCLES = 3000000;
  localparam int   LONG_HOLD    = 400;

  // model of the allocator: bitmap, run lengths, start register,
  // plus the queue of results it predicts
  class alloc_scoreboard;
    bit                       in_use [abu_pkg::NUM_UNITS];
    bit [abu_pkg::CNT_W-1:0]  run_len [abu_pkg::NUM_UNITS];
    bit [16:0]                dyn_start;
    abu_pkg::res_t            want_q [$];
    int unsigned      live_units [$];  // area unit index of each live run
    int               errors;
    int               n_ok, n_zero, n_nospace, n_range, n_notalloc;

    function int unsigned area_base();
      return ((int'(dyn_start) + 15) / 16) * 16;
    endfunction

    function int unsigned area_units();
      int unsigned s;
      s = area_base();
      return (s >= 65536) ? 0 : (65536 - s) / 16;
    endfunction

    function void set_start(bit [16:0] v);
      dyn_start = v;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    // one accepted request beat: work out the result it must give
    function void note_request(logic op, logic [15:0] size, logic [16:0] align,
                               logic [19:0] foff);
      abu_pkg::res_t r;
      int unsigned nbits, nr, al, b, bad, s, ubit, len;
      bit found;
      r = '0;
      nbits = area_units();
      if (op == OP_ALLOC) begin
        if (size == 0) begin
          r.status = abu_pkg::ST_ZERO_SIZE;
        end else begin
          nr = (int'(size) + 15) / 16;
          al = (int'(align) + 15) / 16;
          if (al == 0) al = 1;
          b = 1;
          while (b < al) b = b << 1;
          al = b;
          b = 0;
          found = 0;
          while (b + nr <= nbits) begin
            bad = nbits;
            for (int unsigned j = b; j < b + nr; j++) begin
              if (in_use[j]) begin
                bad = j;
                break;
              end
            end
            if (bad == nbits) begin
              found = 1;
              break;
            end
            b = ((bad + al) / al) * al;
          end
          if (!found) begin
            r.status = abu_pkg::ST_NO_SPACE;
          end else begin
            for (int unsigned j = b; j < b + nr; j++) in_use[j] = 1;
            run_len[b] = nr[abu_pkg::CNT_W-1:0];
            r.status = abu_pkg::ST_OK;
            r.alloc_offset = 16'(area_base() + b * 16);
            live_units.push_back(b);
          end
        end
      end else begin
        s = area_base();
        if (foff < s || foff >= 65536) begin
          r.status = abu_pkg::ST_RANGE;
        end else begin
          ubit = (foff - s) / 16;
          if (ubit >= abu_pkg::NUM_UNITS || !in_use[ubit]) begin
            r.status = abu_pkg::ST_NOT_ALLOC;
          end else begin
            len = run_len[ubit];
            for (int unsigned j = ubit; j < ubit + len && j < abu_pkg::NUM_UNITS; j++)
              in_use[j] = 0;
            run_len[ubit] = 0;
            r.status = abu_pkg::ST_OK;
            r.freed_units = len[abu_pkg::CNT_W-1:0];
            if (len != 0)
              foreach (live_units[k])
                if (live_units[k] == ubit) begin
                  live_units.delete(k);
                  break;
                end
          end
        end
      end
      case (r.status)
        abu_pkg::ST_OK:        n_ok++;
        abu_pkg::ST_ZERO_SIZE: n_zero++;
        abu_pkg::ST_NO_SPACE:  n_nospace++;
        abu_pkg::ST_RANGE:     n_range++;
        default:               n_notalloc++;
      endcase
      want_q.push_back(r);
    endfunction

    function void fail(string what);
      errors++;
      if (errors <= 10) $display("mismatch: %s", what);
    endfunction

    // one accepted result beat against the oldest prediction
    function void check_result(abu_pkg::res_t got);
      abu_pkg::res_t w;
      if (want_q.size() == 0) begin
        fail($sformatf("unexpected result status %0d offset %0d freed %0d",
                       got.status, got.alloc_offset, got.freed_units));
        return;
      end
      w = want_q.pop_front();
      if (got.status != w.status)
        fail($sformatf("status exp %0d got %0d", w.status, got.status));
      if (got.alloc_offset != w.alloc_offset)
        fail($sformatf("alloc_offset exp %0d got %0d", w.alloc_offset,
                       got.alloc_offset));
      if (got.freed_units != w.freed_units)
        fail($sformatf("freed_units exp %0d got %0d", w.freed_units,
                       got.freed_units));
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic        in_op;
  logic [15:0] in_size_bytes;
  logic [16:0] in_align_bytes;
  logic [19:0] in_free_offset;
  logic        out_empty;
  logic        out_pop;
  logic [2:0]  out_status;
  logic [15:0] out_alloc_offset;
  logic [12:0] out_freed_units;
  logic        cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  alloc_scoreboard alloc_sb = new();
  int  cyc = 0;
  logic hold_req;   // asks the result side for one long hold-off
  int  n_cfg;

  aligned_bitmap_unit_allocator dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // watchdog, sized for full-area scans plus stalls per beat
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result side: checks every accepted beat, stalls on its own pattern and
  // counts out the long hold-off when asked
  int rx_mode, rx_left, hold_cnt;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 0;
      rx_mode = 0;
      rx_left = 0;
      hold_cnt = 0;
    end else begin
      if (out_pop && !out_empty)
        alloc_sb.check_result('{out_status, out_alloc_offset, out_freed_units});
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 300);
      end
      rx_left--;
      if (hold_req && hold_cnt < LONG_HOLD) begin
        hold_cnt++;
        out_pop <= 0;
      end else begin
        if (!hold_req) hold_cnt = 0;
        case (rx_mode)
          0:       out_pop <= 1;
          1:       out_pop <= $urandom_range(0, 1);
          2:       out_pop <= (cyc % 7) < 2;   // periodic stall
          default: out_pop <= ($urandom_range(0, 9) == 0);  // mostly stalled
        endcase
      end
    end
  end

  // one request beat; the model sees it at the edge that takes it
  task automatic push_request(logic op, logic [15:0] size, logic [16:0] align,
                              logic [19:0] foff);
    in_push        <= 1;
    in_op          <= op;
    in_size_bytes  <= size;
    in_align_bytes <= align;
    in_free_offset <= foff;
    do @(posedge clk); while (in_full);
    alloc_sb.note_request(op, size, align, foff);
  endtask

  task automatic push_alloc(int size, int align);
    push_request(OP_ALLOC, 16'(size), 17'(align), 20'($urandom));
  endtask

  task automatic push_free(int foff);
    push_request(OP_FREE, 16'($urandom), 17'($urandom), 20'(foff));
  endtask

  task automatic idle_cycles(int n);
    in_push <= 0;
    repeat (n) @(posedge clk);
  endtask

  // wait for every predicted beat to come back, then let the block settle
  task automatic drain();
    in_push <= 0;
    while (alloc_sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic cfg_access(logic wr, logic [31:0] wdata, output logic [31:0] rdata);
    cfg_psel    <= 1;
    cfg_penable <= 0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= REG_DYN_START;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 0;
    cfg_penable <= 0;
  endtask

  // write the start register, mirror it in the model, read it back
  task automatic set_start(int v);
    logic [31:0] rd;
    cfg_access(1, 32'(v), rd);
    alloc_sb.set_start(17'(v));
    cfg_access(0, 32'd0, rd);
    if (rd[16:0] != 17'(v))
      alloc_sb.fail($sformatf("start readback exp %0d got %0d", v, rd[16:0]));
    n_cfg++;
  endtask

  function automatic int pick_align();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return $urandom_range(0, 64);
      2:       return 1 << $urandom_range(0, 16);
      3:       return $urandom_range(0, 65536);
      default: return $urandom_range(0, 32);
    endcase
  endfunction

  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 256);
    if (r < 95) return $urandom_range(257, 4096);
    return $urandom_range(0, 65535);
  endfunction

  // mostly allocates and frees of live runs; the rest is noise
  task automatic random_request();
    int r, idx, base;
    r = $urandom_range(0, 99);
    base = alloc_sb.area_base();
    if (alloc_sb.live_units.size() > 40) r = 50 + r / 2;  // lean toward frees
    if (r < 50 || (r < 85 && alloc_sb.live_units.size() == 0)) begin
      push_alloc(pick_size(), pick_align());
    end else if (r < 85) begin
      idx = $urandom_range(0, alloc_sb.live_units.size() - 1);
      push_free(base + 16 * alloc_sb.live_units[idx]);
    end else begin
      case ($urandom_range(0, 3))
        0: push_free($urandom_range(0, 1048575));
        1: push_free($urandom_range(0, 65535));
        2: push_alloc(0, pick_align());
        default:
          if (alloc_sb.live_units.size() != 0)
            push_free(base + 16 * alloc_sb.live_units[0] + 16);  // one unit past a run start
          else
            push_free(base + $urandom_range(0, 15));
      endcase
    end
  endtask

  // random beats in bursts, most of them followed by a gap
  task automatic random_phase(int n_items, bit long_hold);
    int sent, burst;
    sent = 0;
    if (long_hold) hold_req <= 1;
    while (sent < n_items) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        random_request();
        sent++;
        if (long_hold && sent == 30) hold_req <= 0;
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 8));
    end
    hold_req <= 0;
    drain();
  endtask

  initial begin
    int starts [6];
    n_cfg       = 0;
    hold_req    = 0;
    rst_n       = 0;
    in_push     = 0;
    in_op       = 0;
    in_size_bytes  = 0;
    in_align_bytes = 0;
    in_free_offset = 0;
    cfg_psel    = 0;
    cfg_penable = 0;
    cfg_pwrite  = 0;
    cfg_paddr   = 0;
    cfg_pwdata  = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    set_start(0);

    // directed: whole area, inside-run free, alignment rounding, ranges
    push_alloc(0, 0);            // zero size
    push_alloc(65535, 0);        // whole area at offset 0
    push_alloc(1, 0);            // no space left
    push_free(16);               // inside a run: ok, nothing freed
    push_free(0);                // releases all 4096 units
    push_free(0);                // idle unit
    push_free(1048575);          // beyond the chunk
    push_alloc(1, 65536);        // alignment of the whole area: unit 0 only
    push_alloc(1, 65536);        // unit 0 taken, no space
    push_alloc(17, 17);          // two units at two-unit alignment
    push_alloc(16, 0);           // fills the hole at unit 1
    push_alloc(100, 48);         // alignment three units rounds up to four
    push_free(32);
    push_free(65535);            // last unit, idle
    push_alloc(65535, 1);        // cannot fit
    push_free(0);
    push_free(16);
    push_free(64);
    drain();
    set_start(17);               // unaligned start rounds up to 32
    push_free(16);               // below the area
    push_alloc(1, 0);
    push_free(32);
    drain();
    set_start(65521);            // rounds to the end: empty area
    push_alloc(16, 0);
    push_free(65535);
    push_alloc(0, 0);
    drain();

    // random phases over several start settings, extremes among them
    starts = '{0, 4096, 65536, 17, 61440, 0};
    foreach (starts[i]) begin
      set_start(starts[i]);
      random_phase(125, i == 1);
    end

    $display("run: %0d ok, %0d zero-size, %0d no-space, %0d out-of-range, %0d not-allocated",
             alloc_sb.n_ok, alloc_sb.n_zero, alloc_sb.n_nospace, alloc_sb.n_range,
             alloc_sb.n_notalloc);
    $display("run: %0d start settings, %0d cycles, %0d mismatches", n_cfg, cyc,
             alloc_sb.errors);
    if (alloc_sb.errors == 0 && alloc_sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire
